>>> hw/rtl/sbsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, constants and the SHA-256 round functions and tables.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    // Block geometry.
    localparam int BLOCK_BYTES  = 64;
    localparam int FILL_W       = $clog2(BLOCK_BYTES);
    localparam int MSG_W        = BLOCK_BYTES * 8;
    localparam int BLOCK_BITS   = 512;
    localparam int BLKCNT_W     = 64 - $clog2(BLOCK_BITS);
    localparam int LEN_OFFSET   = 56;
    localparam int ROUNDS       = 64;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 8;
    localparam int IDX_W        = $clog2(DIGEST_WORDS);
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // Eight words: working variables a..h or the chaining value, index 0 first.
    typedef logic [DIGEST_WORDS-1:0][31:0] hash_words_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } sbsh_state_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Initial chaining value.
    function automatic hash_words_t init_hash();
        hash_words_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        init_hash = h;
    endfunction

    // Round constants.
    function automatic word_t round_k(input logic [ROUND_W-1:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage : sbsh_pkg
`default_nettype wire

>>> hw/rtl/sbsh_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, reused for every
// round of every block.
// ----------------------------------------------------------------------------
module sbsh_round
    import sbsh_pkg::*;
(
    input  wire hash_words_t vars_in,   // working variables a..h, a at index 0
    input  wire word_t       k_word,
    input  wire word_t       w_0,       // schedule word used in this round
    input  wire word_t       w_1,
    input  wire word_t       w_9,
    input  wire word_t       w_14,
    output hash_words_t      vars_out,
    output word_t            w_new      // schedule word sixteen rounds ahead
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    // Round function.
    always_comb
    begin
        ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^
              (vars_in[1] & vars_in[2]);
        t1  = vars_in[7] + big_sigma1(vars_in[4]) + ch + k_word + w_0;
        t2  = big_sigma0(vars_in[0]) + maj;

        vars_out[7] = vars_in[6];
        vars_out[6] = vars_in[5];
        vars_out[5] = vars_in[4];
        vars_out[4] = vars_in[3] + t1;
        vars_out[3] = vars_in[2];
        vars_out[2] = vars_in[1];
        vars_out[1] = vars_in[0];
        vars_out[0] = t1 + t2;
    end

    // Message schedule expansion.
    assign w_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_0;

endmodule : sbsh_round
`default_nettype wire

>>> hw/rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a byte that does not close a block is simply stored; a byte that fills a
// block starts a compression (64 rounds of the one round unit, one chaining add).
// End of message: padding and length go in one byte per cycle, then the final
// compressions (one or two), then the eight digest words, one per cycle while
// m_axis_tready is high. No byte is taken during a compression or the digest.
// Reset: asynchronous, active low; clears control state and loads the initial hash.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Takes a message one byte per request, compresses each 64-byte block with a
// single shared round unit, pads the final block and returns the digest.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] has_byte
    input  wire         s_axis_tlast,   // end_of_message

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sbsh_state_t            state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [BLKCNT_W-1:0]    blocks_reg, blocks_next;
    logic [63:0]            total_reg, total_next;
    logic                   fin_reg, fin_next;
    logic                   len_done_reg, len_done_next;
    logic                   pad_first_reg, pad_first_next;
    logic [ROUND_W-1:0]     round_reg, round_next;
    logic [IDX_W-1:0]       out_idx_reg, out_idx_next;
    hash_words_t            hash_reg;
    hash_words_t            vars_reg;
    logic [MSG_W-1:0]       msg_reg;

    logic                   push_en;
    logic [7:0]             push_byte;
    logic                   start_compress;
    logic                   reinit;
    logic                   fill_full;
    hash_words_t            vars_round;
    word_t                  w_new;

    assign fill_full = (fill_reg == FILL_W'(BLOCK_BYTES - 1));

    // Shared round unit.
    sbsh_round u_round (
        .vars_in  (vars_reg),
        .k_word   (round_k(round_reg)),
        .w_0      (msg_reg[MSG_W-1 -: 32]),
        .w_1      (msg_reg[MSG_W-1-32 -: 32]),
        .w_9      (msg_reg[MSG_W-1-32*9 -: 32]),
        .w_14     (msg_reg[MSG_W-1-32*14 -: 32]),
        .vars_out (vars_round),
        .w_new    (w_new)
    );

    // Sequencer: next state and handshake outputs.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        blocks_next    = blocks_reg;
        total_next     = total_reg;
        fin_next       = fin_reg;
        len_done_next  = len_done_reg;
        pad_first_next = pad_first_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        push_en        = 1'b0;
        push_byte      = '0;
        start_compress = 1'b0;
        reinit         = 1'b0;
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    fin_next = s_axis_tlast;
                    if (s_axis_tuser)
                    begin
                        push_en   = 1'b1;
                        push_byte = s_axis_tdata;
                    end
                    if (s_axis_tuser && fill_full)
                    begin
                        blocks_next    = blocks_reg + 1'b1;
                        start_compress = 1'b1;
                        state_next     = ST_ROUND;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end

            // The marker byte once per message, then zeros up to the length field or block end.
            ST_PAD:
            begin
                push_en        = 1'b1;
                push_byte      = pad_first_reg ? PAD_BYTE : 8'h00;
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    total_next = {blocks_reg, fill_reg, 3'b000};
                end
                if (fill_full)
                begin
                    start_compress = 1'b1;
                    state_next     = ST_ROUND;
                end
                else if (fill_reg == FILL_W'(LEN_OFFSET - 1))
                begin
                    state_next = ST_LEN;
                end
            end

            // Bit length, most significant byte first.
            ST_LEN:
            begin
                push_en    = 1'b1;
                push_byte  = total_reg[63:56];
                total_next = {total_reg[55:0], 8'h00};
                if (fill_full)
                begin
                    len_done_next  = 1'b1;
                    start_compress = 1'b1;
                    state_next     = ST_ROUND;
                end
            end

            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == IDX_W'(DIGEST_WORDS - 1))
                    begin
                        reinit         = 1'b1;
                        blocks_next    = '0;
                        fin_next       = 1'b0;
                        len_done_next  = 1'b0;
                        pad_first_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            blocks_reg    <= '0;
            total_reg     <= '0;
            fin_reg       <= 1'b0;
            len_done_reg  <= 1'b0;
            pad_first_reg <= 1'b1;
            round_reg     <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            blocks_reg    <= blocks_next;
            total_reg     <= total_next;
            fin_reg       <= fin_next;
            len_done_reg  <= len_done_next;
            pad_first_reg <= pad_first_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // Chaining value: loaded at reset and after each digest, summed after each block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= init_hash();
        end
        else if (reinit)
        begin
            hash_reg <= init_hash();
        end
        else if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_reg[i] <= hash_reg[i] + vars_reg[i];
            end
        end
    end

    // Working variables.
    always_ff @(posedge clk)
    begin
        if (start_compress)
        begin
            vars_reg <= hash_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            vars_reg <= vars_round;
        end
    end

    // Block buffer, which doubles as the sixteen-word schedule window.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            msg_reg <= {msg_reg[MSG_W-9:0], push_byte};
        end
        else if (state_reg == ST_ROUND)
        begin
            msg_reg <= {msg_reg[MSG_W-33:0], w_new};
        end
    end

    // Digest output.
    assign m_axis_tdata = hash_reg[out_idx_reg];
    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == IDX_W'(DIGEST_WORDS - 1));

endmodule : sha256_byte_stream_hasher
`default_nettype wire

>>> hw/rtl/sbsh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher checker
// Port-level assertions on the hasher, attached by a bind statement.
// ----------------------------------------------------------------------------
module sbsh_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);

    // A stalled digest word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("digest word changed while stalled");

    // No byte is taken while the digest is being returned.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest is pending");

    // The last flag marks exactly the eighth word.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("last flag does not match word index");

    // Words follow one another in order.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest words out of order");

    // After the last word the hasher goes back to taking bytes.
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("hasher did not return to idle after digest");

endmodule : sbsh_checker

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);
`default_nettype wire
